// File: rtl/rlvs_pkg.sv
// Package for the run-length vector store: sizes, codes, channel payloads and the
// layout of a segment table entry. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rlvs_pkg;

	// Sizes of the stores and of the element fields.
	localparam int MAX_SEGMENTS  = 256;
	localparam int MAX_LITERALS  = 4096;
	localparam int VALUE_BITS    = 32;
	localparam int POSITION_BITS = 24;

	localparam int SEG_ADDR_W = $clog2(MAX_SEGMENTS);
	localparam int SEG_CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int LIT_ADDR_W = $clog2(MAX_LITERALS);
	localparam int LIT_CNT_W  = $clog2(MAX_LITERALS + 1);
	localparam int LIT_SUM_W  = POSITION_BITS + 1;

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		OP_APPEND_VALUE = 2'd0,
		OP_APPEND_RUN   = 2'd1,
		OP_READ         = 2'd2,
		OP_CLEAR        = 2'd3
	} opcode_t;

	// Status codes of a result item.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE,
		ST_FETCH,
		ST_OFFSET,
		ST_LITERAL,
		ST_DONE
	} state_t;

	// Payload of one input item.
	typedef struct packed {
		opcode_t                  opcode;
		logic [POSITION_BITS-1:0] position;
		logic [POSITION_BITS-1:0] run_length;
		logic [VALUE_BITS-1:0]    data_in;
	} item_t;

	// Payload of one result item.
	typedef struct packed {
		logic [VALUE_BITS-1:0]    data_out;
		logic                     found;
		status_t                  status;
		logic [POSITION_BITS-1:0] element_total;
	} result_t;

	// One entry of the segment table. The payload is the run value of a run, or
	// the literal store offset of a literal block.
	typedef struct packed {
		logic [POSITION_BITS-1:0] start;
		logic                     is_run;
		logic [VALUE_BITS-1:0]    payload;
	} seg_entry_t;

	localparam int SEG_ENTRY_W = $bits(seg_entry_t);

endpackage

`default_nettype wire

// File: rtl/rlvs_in_if.sv
// Input channel of the run-length vector store: valid, ready and one item.
// It depends on rlvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rlvs_in_if;
	import rlvs_pkg::*;

	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: rtl/rlvs_out_if.sv
// Result channel of the run-length vector store: valid, ready and one result.
// It depends on rlvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rlvs_out_if;
	import rlvs_pkg::*;

	logic    valid;
	logic    ready;
	result_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: rtl/run_length_vector_store_top.sv
// Run-length vector store: top level with the sequencer, the counters and the two memories.
// It depends on rlvs_pkg, rlvs_in_if, rlvs_out_if and rlvs_ram.
`timescale 1ns / 1ps
`default_nettype none

// A compressed vector is held as a table of segments (runs and literal blocks) in
// one memory and the literal values in a second. Each item gives exactly one result.
// Appends and clear set the result register when they are transferred, with no
// search. A read of a position inside the vector binary-searches the segment
// starts through the single read port of the segment memory, with a probe state
// and a compare state per probe, then fetches the segment, and for a literal
// block reads the literal store. One item is in work at a time; the next is taken
// once the previous result has moved to the output register. No clearing pass is
// needed after reset or clear: only entries written since are ever read.
module run_length_vector_store_top (
	input wire logic   clk,
	input wire logic   arst_n,
	rlvs_in_if.sink    req,
	rlvs_out_if.source rsp
);
	import rlvs_pkg::*;

	state_t state_q, state_d;

	// Counters and the kind of the last segment.
	logic [POSITION_BITS-1:0] elem_cnt_q;
	logic [SEG_CNT_W-1:0]     seg_cnt_q;
	logic [LIT_CNT_W-1:0]     lit_cnt_q;
	logic                     last_is_run_q;

	// Search and result registers.
	logic [SEG_ADDR_W-1:0]    lo_q, hi_q, mid_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] off_q;
	logic [LIT_CNT_W-1:0]     base_q;
	logic [VALUE_BITS-1:0]    res_data_q;
	logic                     res_found_q;
	status_t                  res_status_q;
	logic                     rsp_valid_q;
	result_t                  rsp_q;

	// Memory ports.
	logic                  seg_we;
	logic [SEG_ADDR_W-1:0] seg_waddr, seg_raddr;
	seg_entry_t            seg_wdata, seg_rdata;
	logic [SEG_ENTRY_W-1:0] seg_rdata_raw;
	logic                  lit_we;
	logic [LIT_ADDR_W-1:0] lit_waddr, lit_raddr;
	logic [VALUE_BITS-1:0] lit_rdata;

	logic                     accept;
	logic                     extend;
	logic                     elem_full, lit_full, seg_full;
	logic                     val_refuse, run_refuse;
	logic                     read_miss;
	logic [POSITION_BITS-1:0] room;
	logic [SEG_ADDR_W:0]      mid_sum;
	logic [SEG_ADDR_W-1:0]    mid;
	logic [LIT_SUM_W-1:0]     lit_index;
	logic                     lit_in_range;

	rlvs_ram #(.WIDTH(SEG_ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
		.clk   (clk),
		.we    (seg_we),
		.waddr (seg_waddr),
		.wdata (seg_wdata),
		.raddr (seg_raddr),
		.rdata (seg_rdata_raw)
	);

	rlvs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LITERALS)) u_lit_ram (
		.clk   (clk),
		.we    (lit_we),
		.waddr (lit_waddr),
		.wdata (req.item.data_in),
		.raddr (lit_raddr),
		.rdata (lit_rdata)
	);

	assign seg_rdata = seg_entry_t'(seg_rdata_raw);

	// Handshake and the checks of an incoming item against the counters.
	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign extend     = (seg_cnt_q != '0) && !last_is_run_q;
	assign elem_full  = (elem_cnt_q == POS_MAX);
	assign lit_full   = (lit_cnt_q >= LIT_CNT_W'(MAX_LITERALS));
	assign seg_full   = (seg_cnt_q >= SEG_CNT_W'(MAX_SEGMENTS));
	assign room       = POS_MAX - elem_cnt_q;
	assign val_refuse = elem_full || lit_full || (!extend && seg_full);
	assign run_refuse = (req.item.run_length > room) || seg_full;
	assign read_miss  = (req.item.position >= elem_cnt_q) || (seg_cnt_q == '0);

	// Probe index of the search, rounded up.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (SEG_ADDR_W + 1)'(1);
	assign mid     = mid_sum[SEG_ADDR_W:1];

	// Literal store index of the read position.
	assign lit_index    = LIT_SUM_W'(base_q) + LIT_SUM_W'(off_q);
	assign lit_in_range = (lit_index < LIT_SUM_W'(MAX_LITERALS));

	assign seg_waddr = seg_cnt_q[SEG_ADDR_W-1:0];
	assign lit_waddr = lit_cnt_q[LIT_ADDR_W-1:0];
	assign lit_raddr = lit_index[LIT_ADDR_W-1:0];

	// Next state and memory controls.
	always_comb begin
		state_d           = state_q;
		seg_we            = 1'b0;
		lit_we            = 1'b0;
		seg_raddr         = lo_q;
		seg_wdata.start   = elem_cnt_q;
		seg_wdata.is_run  = (req.item.opcode == OP_APPEND_RUN);
		seg_wdata.payload = (req.item.opcode == OP_APPEND_RUN) ? req.item.data_in
			: VALUE_BITS'(lit_cnt_q);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DONE;
					case (req.item.opcode)
						OP_APPEND_VALUE: begin
							if (!val_refuse) begin
								lit_we = 1'b1;
								seg_we = !extend;
							end
						end
						OP_APPEND_RUN: begin
							if ((req.item.run_length != '0) && !run_refuse) begin
								seg_we = 1'b1;
							end
						end
						OP_READ: begin
							if (!read_miss) begin
								state_d = ST_PROBE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_PROBE: begin
				if (lo_q < hi_q) begin
					seg_raddr = mid;
					state_d   = ST_COMPARE;
				end else begin
					seg_raddr = lo_q;
					state_d   = ST_FETCH;
				end
			end
			ST_COMPARE: begin
				state_d = ST_PROBE;
			end
			ST_FETCH: begin
				state_d = seg_rdata.is_run ? ST_DONE : ST_OFFSET;
			end
			ST_OFFSET: begin
				state_d = lit_in_range ? ST_LITERAL : ST_DONE;
			end
			ST_LITERAL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Counters, updated when an append or a clear is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q    <= '0;
			seg_cnt_q     <= '0;
			lit_cnt_q     <= '0;
			last_is_run_q <= 1'b0;
		end else if (accept) begin
			case (req.item.opcode)
				OP_APPEND_VALUE: begin
					if (!val_refuse) begin
						elem_cnt_q    <= elem_cnt_q + POSITION_BITS'(1);
						lit_cnt_q     <= lit_cnt_q + LIT_CNT_W'(1);
						last_is_run_q <= 1'b0;
						if (!extend) begin
							seg_cnt_q <= seg_cnt_q + SEG_CNT_W'(1);
						end
					end
				end
				OP_APPEND_RUN: begin
					if ((req.item.run_length != '0) && !run_refuse) begin
						elem_cnt_q    <= elem_cnt_q + req.item.run_length;
						seg_cnt_q     <= seg_cnt_q + SEG_CNT_W'(1);
						last_is_run_q <= 1'b1;
					end
				end
				OP_READ: begin
				end
				default: begin
					elem_cnt_q    <= '0;
					seg_cnt_q     <= '0;
					lit_cnt_q     <= '0;
					last_is_run_q <= 1'b0;
				end
			endcase
		end
	end

	// Search bounds and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pos_q        <= req.item.position;
					lo_q         <= '0;
					hi_q         <= SEG_ADDR_W'(seg_cnt_q - SEG_CNT_W'(1));
					res_data_q   <= '0;
					res_found_q  <= 1'b0;
					res_status_q <= STATUS_OK;
					case (req.item.opcode)
						OP_APPEND_VALUE: begin
							if (val_refuse) begin
								res_status_q <= STATUS_FULL;
							end
						end
						OP_APPEND_RUN: begin
							if ((req.item.run_length != '0) && run_refuse) begin
								res_status_q <= STATUS_FULL;
							end
						end
						OP_READ: begin
							if (read_miss) begin
								res_status_q <= STATUS_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_PROBE: begin
				mid_q <= mid;
			end
			ST_COMPARE: begin
				if (seg_rdata.start <= pos_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q - SEG_ADDR_W'(1);
				end
			end
			ST_FETCH: begin
				res_found_q <= 1'b1;
				off_q       <= pos_q - seg_rdata.start;
				base_q      <= LIT_CNT_W'(seg_rdata.payload);
				if (seg_rdata.is_run) begin
					res_data_q <= seg_rdata.payload;
				end
			end
			ST_LITERAL: begin
				res_data_q <= lit_rdata;
			end
			default: begin
			end
		endcase
	end

	// Output register: a result waits here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
			rsp_q.data_out      <= res_data_q;
			rsp_q.found         <= res_found_q;
			rsp_q.status        <= res_status_q;
			rsp_q.element_total <= elem_cnt_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.item  = rsp_q;

endmodule

`default_nettype wire

// File: rtl/rlvs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module rlvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and read through an output register; a read of the address being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/rlvs_checker.sv
// Port checker for the run-length vector store and the bind that attaches it.
// It depends on rlvs_pkg and run_length_vector_store_top.
`timescale 1ns / 1ps
`default_nettype none

module rlvs_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              req_valid,
	input wire logic                              req_ready,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic [rlvs_pkg::VALUE_BITS-1:0]    rsp_data_out,
	input wire logic                              rsp_found,
	input wire logic [1:0]                        rsp_status,
	input wire logic [rlvs_pkg::POSITION_BITS-1:0] rsp_element_total
);
	import rlvs_pkg::*;

	// A stalled result holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
			&& $stable(rsp_found) && $stable(rsp_status) && $stable(rsp_element_total))
		else $error("result changed while stalled");

	// One item is in work at a time: right after a transfer the input closes.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input open right after a transfer");

	// A found read always carries status ok.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_status == STATUS_OK)
		else $error("found result with a bad status");

	// A result without a found element reads as zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_data_out == '0)
		else $error("nonzero data without a found element");

endmodule

bind run_length_vector_store_top rlvs_checker u_rlvs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_data_out      (rsp.item.data_out),
	.rsp_found         (rsp.item.found),
	.rsp_status        (rsp.item.status),
	.rsp_element_total (rsp.item.element_total)
);

`default_nettype wire

// File: bench/run_length_vector_store_top_tb.sv
// Self-checking testbench for the run-length vector store top level.
// It depends on rlvs_pkg, rlvs_in_if, rlvs_out_if and the RTL under rtl/.
`timescale 1ns / 1ps

module run_length_vector_store_top_tb;
	import rlvs_pkg::*;

	// Budget for about 650 items, with the slowest phase and the long hold-off on
	// the result side, taken about five times over.
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int DRAIN_CYCLES = 30;

	logic clk;
	logic arst_n;

	rlvs_in_if  req_if();
	rlvs_out_if rsp_if();

	run_length_vector_store_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the compressed vector, updated on every input transfer.
	logic [POSITION_BITS-1:0] seg_first   [MAX_SEGMENTS];
	logic                     seg_repeats [MAX_SEGMENTS];
	logic [VALUE_BITS-1:0]    seg_data    [MAX_SEGMENTS];
	logic [VALUE_BITS-1:0]    lit_vals    [MAX_LITERALS];
	int unsigned              elems = 0;
	int unsigned              segs  = 0;
	int unsigned              lits  = 0;

	result_t     vector_results_due [$];
	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;
	int          hold_off_left  = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// Finds the last segment whose start is not above the position.
	function automatic int unsigned locate_segment(int unsigned pos);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = segs - 1;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (seg_first[mid] <= pos)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// Applies one item to the shadow vector and returns the result it gives.
	function automatic result_t vector_op_result(item_t it);
		result_t     r;
		int unsigned k;
		int unsigned idx;
		int unsigned len;
		logic        open_new;
		r = '0;
		r.status = STATUS_OK;
		case (it.opcode)
			OP_APPEND_VALUE: begin
				// A value extends a trailing literal block, or opens a new one.
				open_new = (segs == 0) || seg_repeats[segs-1];
				if (elems >= POS_MAX || lits >= MAX_LITERALS ||
				    (open_new && segs >= MAX_SEGMENTS)) begin
					r.status = STATUS_FULL;
				end else begin
					if (open_new) begin
						seg_first[segs]   = elems;
						seg_repeats[segs] = 1'b0;
						seg_data[segs]    = lits;
						segs++;
					end
					lit_vals[lits] = it.data_in;
					lits++;
					elems++;
				end
			end
			OP_APPEND_RUN: begin
				// A zero-length run changes nothing and still reports success.
				len = it.run_length;
				if (len != 0) begin
					if (len > POS_MAX - elems || segs >= MAX_SEGMENTS) begin
						r.status = STATUS_FULL;
					end else begin
						seg_first[segs]   = elems;
						seg_repeats[segs] = 1'b1;
						seg_data[segs]    = it.data_in;
						segs++;
						elems += len;
					end
				end
			end
			OP_READ: begin
				if (it.position >= elems || segs == 0) begin
					r.status = STATUS_RANGE;
				end else begin
					k = locate_segment(it.position);
					if (seg_repeats[k]) begin
						r.data_out = seg_data[k];
					end else begin
						idx = seg_data[k] + (it.position - seg_first[k]);
						if (idx < MAX_LITERALS)
							r.data_out = lit_vals[idx];
					end
					r.found = 1'b1;
				end
			end
			default: begin
				elems = 0;
				segs  = 0;
				lits  = 0;
			end
		endcase
		r.element_total = elems;
		return r;
	endfunction

	// Compares one result transfer with the oldest outstanding prediction.
	task automatic check_result(result_t got);
		result_t want;
		if (vector_results_due.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			mismatch_count++;
		end else begin
			want = vector_results_due.pop_front();
			if (got.data_out !== want.data_out) begin
				$display("%0t: data_out expected %h, actual %h", $time,
				         want.data_out, got.data_out);
				mismatch_count++;
			end
			if (got.found !== want.found) begin
				$display("%0t: found expected %b, actual %b", $time, want.found, got.found);
				mismatch_count++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, actual %0d", $time,
				         want.status, got.status);
				mismatch_count++;
			end
			if (got.element_total !== want.element_total) begin
				$display("%0t: element_total expected %h, actual %h", $time,
				         want.element_total, got.element_total);
				mismatch_count++;
			end
		end
	endtask

	// Result side: checks each transfer, then stalls at random or for a hold-off.
	initial begin : result_sink
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				check_result(rsp_if.item);
			if (hold_off_left > 0) begin
				hold_off_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic set_idle(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Offers one item after a random gap and waits for its transfer. Valid is
	// left high so that the next item can follow without a bubble.
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.item  <= it;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		vector_results_due.push_back(vector_op_result(it));
	endtask

	task automatic send_op(opcode_t op, logic [POSITION_BITS-1:0] pos,
	                       logic [POSITION_BITS-1:0] len, logic [VALUE_BITS-1:0] value);
		item_t it;
		it.opcode     = op;
		it.position   = pos;
		it.run_length = len;
		it.data_in    = value;
		send_item(it);
	endtask

	// Stops offering items and waits until every result has been checked.
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (vector_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reads a handful of random positions inside the vector, then one past its end.
	task automatic read_spread(int count);
		repeat (count) begin
			send_op(OP_READ, $urandom_range(elems - 1, 0), $urandom, $urandom);
		end
		send_op(OP_READ, elems, $urandom, $urandom);
	endtask

	// Every operation on a small vector, reads at every segment boundary, the
	// empty vector and a zero-length run.
	task automatic test_basic_ops();
		send_op(OP_CLEAR, 0, 0, 0);
		send_op(OP_READ, 0, 0, 0);
		send_op(OP_APPEND_RUN, 0, 0, 32'hDEAD_BEEF);
		send_op(OP_APPEND_VALUE, 0, 0, 32'hFFFF_FFFF);
		send_op(OP_APPEND_VALUE, 24'hFFFFFF, 24'hFFFFFF, 32'h0000_0000);
		send_op(OP_APPEND_RUN, 0, 3, 32'hA5A5_A5A5);
		send_op(OP_APPEND_VALUE, 0, 0, 32'h1234_5678);
		send_op(OP_APPEND_RUN, 0, 1, 32'h0000_0000);
		send_op(OP_READ, 0, 0, 0);
		send_op(OP_READ, 1, 0, 0);
		send_op(OP_READ, 2, 0, 0);
		send_op(OP_READ, 4, 0, 0);
		send_op(OP_READ, 5, 0, 0);
		send_op(OP_READ, 6, 0, 0);
		send_op(OP_READ, 7, 0, 0);
		send_op(OP_READ, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
		send_op(OP_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
		send_op(OP_READ, 0, 0, 0);
		drain();
	endtask

	// Builds pairs of a literal block and a two-element run.
	task automatic add_segment_pairs(int pairs);
		repeat (pairs) begin
			send_op(OP_APPEND_VALUE, $urandom, $urandom, $urandom);
			send_op(OP_APPEND_RUN, $urandom, 2, $urandom);
		end
	endtask

	// Fills the segment table, once ending in a run and once in a literal block.
	task automatic test_segment_table_full();
		send_op(OP_CLEAR, 0, 0, 0);
		add_segment_pairs(MAX_SEGMENTS / 2);
		send_op(OP_APPEND_VALUE, 0, 0, $urandom);
		send_op(OP_APPEND_RUN, 0, 3, $urandom);
		send_op(OP_APPEND_RUN, 0, 0, $urandom);
		send_op(OP_READ, 0, 0, 0);
		send_op(OP_READ, elems - 1, 0, 0);
		read_spread(10);

		// A full table still lets a trailing literal block grow.
		send_op(OP_CLEAR, 0, 0, 0);
		add_segment_pairs(MAX_SEGMENTS / 2 - 1);
		send_op(OP_APPEND_RUN, 0, 1, $urandom);
		send_op(OP_APPEND_VALUE, 0, 0, $urandom);
		send_op(OP_APPEND_VALUE, 0, 0, $urandom);
		send_op(OP_APPEND_RUN, 0, 4, $urandom);
		send_op(OP_READ, elems - 1, 0, 0);
		send_op(OP_READ, elems - 2, 0, 0);
		read_spread(10);
		drain();
	endtask

	// Runs that reach and overshoot the largest element count.
	task automatic test_element_limit();
		send_op(OP_CLEAR, 0, 0, 0);
		send_op(OP_APPEND_RUN, 0, POS_MAX, 32'h5555_AAAA);
		send_op(OP_APPEND_VALUE, 0, 0, $urandom);
		send_op(OP_APPEND_RUN, 0, 1, $urandom);
		send_op(OP_READ, POS_MAX - 1, 0, 0);
		send_op(OP_READ, POS_MAX, 0, 0);
		send_op(OP_READ, 24'h800000, 0, 0);
		send_op(OP_CLEAR, 0, 0, 0);
		send_op(OP_APPEND_VALUE, 0, 0, 32'h0000_0007);
		send_op(OP_APPEND_RUN, 0, POS_MAX - 1, 32'hFFFF_FFFF);
		send_op(OP_READ, 0, 0, 0);
		send_op(OP_READ, POS_MAX - 1, 0, 0);
		send_op(OP_CLEAR, 0, 0, 0);
		send_op(OP_APPEND_VALUE, 0, 0, $urandom);
		send_op(OP_APPEND_RUN, 0, POS_MAX, $urandom);
		send_op(OP_READ, 0, 0, 0);
		drain();
	endtask

	// The result side holds off for a long stretch while items keep coming,
	// so the block fills up and stalls its input.
	task automatic test_output_hold_off();
		hold_off_left = 300;
		repeat (8) begin
			send_op(OP_APPEND_VALUE, $urandom, $urandom, $urandom);
			send_op(OP_APPEND_RUN, $urandom, $urandom_range(9, 1), $urandom);
			send_op(OP_READ, $urandom_range(elems - 1, 0), $urandom, $urandom);
		end
		drain();
	endtask

	// Mostly appends and in-range reads with random content; the rest are
	// clears, zero-length and huge runs, and reads past the end.
	task automatic test_random_mix(int count);
		item_t       it;
		int unsigned pick;
		repeat (count) begin
			it.position   = $urandom;
			it.run_length = $urandom;
			it.data_in    = $urandom;
			pick = $urandom_range(99);
			if (pick < 3) begin
				it.opcode = OP_CLEAR;
			end else if (pick < 40) begin
				it.opcode = OP_APPEND_VALUE;
			end else if (pick < 58) begin
				it.opcode = OP_APPEND_RUN;
				pick = $urandom_range(99);
				if (pick < 8)
					it.run_length = '0;
				else if (pick < 94)
					it.run_length = $urandom_range(16, 1);
			end else begin
				it.opcode = OP_READ;
				pick = $urandom_range(99);
				if (pick < 75 && elems > 0)
					it.position = $urandom_range(elems - 1, 0);
				else if (pick < 90)
					it.position = elems + $urandom_range(3);
			end
			send_item(it);
		end
		drain();
	endtask

	// Test sequence.
	initial begin : stimulus
		arst_n        <= 1'b0;
		req_if.valid  <= 1'b0;
		req_if.item   <= '0;
		set_idle(21, 58);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_segment_table_full();
		test_element_limit();
		test_output_hold_off();
		test_random_mix(20);
		set_idle(58, 21);
		test_random_mix(20);
		set_idle(0, 0);
		test_random_mix(20);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/rlvs_pkg.sv
rtl/rlvs_in_if.sv
rtl/rlvs_out_if.sv
rtl/rlvs_ram.sv
rtl/run_length_vector_store_top.sv
rtl/rlvs_checker.sv
bench/run_length_vector_store_top_tb.sv
